// ===== design/lggs_pkg.sv =====
// Shared types, codes and constants for the life grid generation step block.
// No dependencies; used by lggs_ram's users and life_grid_generation_step.
package lggs_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  localparam int SIZE_W = 7;
  localparam logic [SIZE_W-1:0] SIZE_RST = 7'd64;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic       cell_value;
  } in_word_t;

  typedef struct packed {
    logic cell_alive;
    logic status;
  } out_word_t;

  // live neighbor count of eight one-bit neighbors
  function automatic logic [3:0] count8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

endpackage

// ===== design/lggs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lggs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/life_grid_generation_step.sv =====
// Top level of the bounded B3/S23 life grid: cell write, cell read, generation advance.
// Depends on lggs_pkg and lggs_ram.
//
// One word in gives one word out. The grid sits in one RAM, one row of cells per RAM word,
// and a per-row valid flag makes every row read as dead after reset, so no clearing pass
// is needed. A write or read passes from acceptance to the result being offered through
// accept, row read-modify-write or bit select, and result load. An advance streams the rows
// in use through a three-row window on the single RAM read port and writes each new row
// back on the write port, one row per cycle. Out-of-range addresses and the unused
// command skip the cell step and go straight to the result load. The block takes
// no new word while one is in progress; a finished result waits in the output register.
module life_grid_generation_step #(
  parameter int MAX_ROWS = lggs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lggs_pkg::MAX_COLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lggs_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lggs_pkg::out_word_t                 out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lggs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lggs_pkg::SIZE_W-1:0]         cfg_data
);

  localparam int AW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int SW  = $clog2(MAX_ROWS + 4);
  localparam int CSW = $clog2(MAX_COLS + 1);
  localparam int RXW = (SW > lggs_pkg::SIZE_W) ? SW : lggs_pkg::SIZE_W;
  localparam int CXW = (CSW > lggs_pkg::SIZE_W) ? CSW : lggs_pkg::SIZE_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CELL = 2'd1;
  localparam logic [1:0] S_ADV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [lggs_pkg::SIZE_W-1:0] row_count_r, col_count_r;
  logic [SW-1:0]               rows_eff;
  logic [CSW-1:0]              cols_eff;
  logic [MAX_COLS-1:0]         col_mask;

  logic [1:0]          state_r, state_nxt;
  logic [SW-1:0]       step_r, wr_step;
  logic [1:0]          cmd_r;
  logic [AW-1:0]       row_idx_r;
  logic [CW-1:0]       col_idx_r;
  logic                value_r;
  logic [MAX_ROWS-1:0] row_valid_r;
  logic                rd_valid_r;

  logic                mem_we;
  logic [AW-1:0]       mem_rd_addr, mem_wr_addr;
  logic [MAX_COLS-1:0] mem_wr_data, mem_rd_data, rd_row;
  logic [MAX_COLS-1:0] win0_r, win1_r, win2_r, fresh;

  logic                res_alive_r, res_status_r;
  logic                out_valid_r;
  lggs_pkg::out_word_t out_word_r;

  logic in_accept, addr_ok, shift_en, wb_en, adv_last, out_load;

  // effective sizes: zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (row_count_r == '0) begin
      rows_eff = SW'(1);
    end else if (RXW'(row_count_r) > RXW'(MAX_ROWS)) begin
      rows_eff = SW'(MAX_ROWS);
    end else begin
      rows_eff = SW'(row_count_r);
    end
    if (col_count_r == '0) begin
      cols_eff = CSW'(1);
    end else if (CXW'(col_count_r) > CXW'(MAX_COLS)) begin
      cols_eff = CSW'(MAX_COLS);
    end else begin
      cols_eff = CSW'(col_count_r);
    end
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = CXW'(c) < CXW'(cols_eff);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign addr_ok   = (RXW'(in_word.cell_row) < RXW'(rows_eff)) &&
                     (CXW'(in_word.cell_col) < CXW'(cols_eff));

  assign wr_step  = step_r - SW'(3);
  assign shift_en = (step_r != '0) && (step_r <= rows_eff);
  assign wb_en    = (step_r >= SW'(3)) && (wr_step < rows_eff);
  assign adv_last = (step_r == rows_eff + SW'(2));
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign rd_row      = rd_valid_r ? mem_rd_data : '0;
  assign mem_rd_addr = (state_r == S_ADV) ? step_r[AW-1:0] : AW'(in_word.cell_row);

  // window rows: win0 above, win1 current, win2 below
  always_comb begin
    logic [MAX_COLS-1:0] a, b, d;
    logic [3:0]          nbr;
    a = win0_r & col_mask;
    b = win1_r & col_mask;
    d = win2_r & col_mask;
    for (int c = 0; c < MAX_COLS; c++) begin
      nbr = lggs_pkg::count8({
        (c > 0) ? a[(c > 0) ? c - 1 : 0] : 1'b0, a[c],
        (c < MAX_COLS - 1) ? a[(c < MAX_COLS - 1) ? c + 1 : c] : 1'b0,
        (c > 0) ? b[(c > 0) ? c - 1 : 0] : 1'b0,
        (c < MAX_COLS - 1) ? b[(c < MAX_COLS - 1) ? c + 1 : c] : 1'b0,
        (c > 0) ? d[(c > 0) ? c - 1 : 0] : 1'b0, d[c],
        (c < MAX_COLS - 1) ? d[(c < MAX_COLS - 1) ? c + 1 : c] : 1'b0});
      fresh[c] = (nbr == 4'd3) || ((nbr == 4'd2) && b[c]);
    end
  end

  always_comb begin
    mem_we      = 1'b0;
    mem_wr_addr = row_idx_r;
    mem_wr_data = (rd_row & ~(MAX_COLS'(1) << col_idx_r)) |
                  (MAX_COLS'(value_r) << col_idx_r);
    if (state_r == S_CELL && cmd_r == lggs_pkg::CMD_WRITE) begin
      mem_we = 1'b1;
    end else if (state_r == S_ADV && wb_en) begin
      mem_we      = 1'b1;
      mem_wr_addr = wr_step[AW-1:0];
      mem_wr_data = (fresh & col_mask) | (win1_r & ~col_mask);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_word.cmd == lggs_pkg::CMD_ADVANCE) begin
            state_nxt = S_ADV;
          end else if ((in_word.cmd inside {lggs_pkg::CMD_WRITE, lggs_pkg::CMD_READ}) &&
                       addr_ok) begin
            state_nxt = S_CELL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_CELL: state_nxt = S_DONE;
      S_ADV: begin
        if (adv_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      row_count_r <= lggs_pkg::SIZE_RST;
      col_count_r <= lggs_pkg::SIZE_RST;
      row_valid_r <= '0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lggs_pkg::REG_ROW_COUNT: row_count_r <= cfg_data;
          lggs_pkg::REG_COL_COUNT: col_count_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_accept) begin
        step_r <= '0;
      end else if (state_r == S_ADV) begin
        step_r <= step_r + SW'(1);
      end
      if (state_r == S_CELL && cmd_r == lggs_pkg::CMD_WRITE) begin
        row_valid_r[row_idx_r] <= 1'b1;
      end else if (state_r == S_ADV && wb_en) begin
        row_valid_r[wr_step[AW-1:0]] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_valid_r <= row_valid_r[mem_rd_addr];
    if (in_accept) begin
      cmd_r        <= in_word.cmd;
      row_idx_r    <= AW'(in_word.cell_row);
      col_idx_r    <= CW'(in_word.cell_col);
      value_r      <= in_word.cell_value;
      win0_r       <= '0;
      win1_r       <= '0;
      win2_r       <= '0;
      res_alive_r  <= 1'b0;
      res_status_r <= (in_word.cmd inside {lggs_pkg::CMD_WRITE, lggs_pkg::CMD_READ}) &&
                      !addr_ok;
    end else if (state_r == S_ADV) begin
      win0_r <= win1_r;
      win1_r <= win2_r;
      win2_r <= shift_en ? rd_row : '0;
    end
    if (state_r == S_CELL && cmd_r == lggs_pkg::CMD_READ) begin
      res_alive_r <= rd_row[col_idx_r];
    end
    if (out_load) begin
      out_word_r.cell_alive <= res_alive_r;
      out_word_r.status     <= res_status_r;
    end
  end

  lggs_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r != S_IDLE)
    else $error("accepted word did not start processing");

  a_grid_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_ADV) ||
               (state_r == S_CELL && cmd_r == lggs_pkg::CMD_WRITE))
    else $error("grid written outside a write or advance");

  a_adv_rows_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == S_ADV) |-> wr_step < rows_eff)
    else $error("advance wrote a row beyond the grid in use");

  a_write_marks_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CELL && cmd_r == lggs_pkg::CMD_WRITE) |=> row_valid_r[$past(row_idx_r)])
    else $error("written row not marked valid");

endmodule
